### rtl/aht_pkg.sv
// ----------------------------------------------------------------------------
// aht_pkg
// Shared widths, operation codes and status codes of the address
// reference-count hash table.
// ----------------------------------------------------------------------------
package aht_pkg;

    localparam int ADDR_W           = 48;
    localparam int COUNT_W          = 32;
    localparam int KIND_W           = 2;
    localparam int STATUS_W         = 2;
    localparam int SLOT_W           = 6;
    localparam int WORD_SHIFT       = 2;
    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_ADDRESS_BITS = 48;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam kind_t KIND_INSERT = 2'd0;
    localparam kind_t KIND_DELETE = 2'd1;
    localparam kind_t KIND_LOOKUP = 2'd2;
    localparam kind_t KIND_SET    = 2'd3;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_NOT_FOUND = 2'd1;
    localparam status_t STATUS_FULL      = 2'd2;
    localparam status_t STATUS_ZERO_ADDR = 2'd3;

endpackage

### rtl/aht_req_if.sv
// ----------------------------------------------------------------------------
// aht_req_if
// Request channel: operation kind, object address and new count.
// ----------------------------------------------------------------------------
interface aht_req_if import aht_pkg::*; ();

    logic                 valid;
    logic                 ready;
    kind_t                kind;
    logic [ADDR_W-1:0]    address;
    logic [COUNT_W-1:0]   new_count;

    modport source (output valid, output kind, output address, output new_count,
                    input ready);
    modport sink   (input valid, input kind, input address, input new_count,
                    output ready);

endinterface

### rtl/aht_rsp_if.sv
// ----------------------------------------------------------------------------
// aht_rsp_if
// Response channel: status, stored count and slot index.
// ----------------------------------------------------------------------------
interface aht_rsp_if import aht_pkg::*; ();

    logic                 valid;
    logic                 ready;
    status_t              status;
    logic [COUNT_W-1:0]   count_out;
    logic [SLOT_W-1:0]    slot;

    modport source (output valid, output status, output count_out, output slot,
                    input ready);
    modport sink   (input valid, input status, input count_out, input slot,
                    output ready);

endinterface

### rtl/aht_home.sv
// ----------------------------------------------------------------------------
// aht_home
// Home slot unit: (key / word size) mod table depth. A power-of-two depth
// registers the low index bits of the word address; any other depth runs a
// restoring remainder, four bits a cycle.
// ----------------------------------------------------------------------------
module aht_home import aht_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = DEF_ADDRESS_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [KEY_BITS-1:0]             key,
    output logic                            done,
    output logic [$clog2(TABLE_DEPTH)-1:0]  home
);

    localparam int  IDX_W  = $clog2(TABLE_DEPTH);
    localparam int  Q_W    = KEY_BITS - WORD_SHIFT;
    localparam bit  IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic             done_reg;
            logic [IDX_W-1:0] home_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                    home_reg <= '0;
                end
                else
                begin
                    done_reg <= start;
                    if (start)
                    begin
                        home_reg <= key[IDX_W+WORD_SHIFT-1:WORD_SHIFT];
                    end
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end
        else begin : g_rem
            localparam int DIGIT  = 4;
            localparam int STEPS  = (Q_W + DIGIT - 1) / DIGIT;
            localparam int PADW   = STEPS * DIGIT;
            localparam int R_W    = IDX_W + 1;
            localparam int SW     = $clog2(STEPS + 1);
            localparam logic [R_W-1:0] DEPTH_R = R_W'(TABLE_DEPTH);

            logic             busy_reg,  busy_next;
            logic             done_reg,  done_next;
            logic [PADW-1:0]  div_reg,   div_next;
            logic [IDX_W-1:0] rem_reg,   rem_next;
            logic [SW-1:0]    step_reg,  step_next;

            always_comb
            begin
                logic [R_W-1:0]   t;
                logic [IDX_W-1:0] r;
                busy_next = busy_reg;
                done_next = 1'b0;
                div_next  = div_reg;
                rem_next  = rem_reg;
                step_next = step_reg;
                r = rem_reg;
                for (int i = 0; i < DIGIT; i++)
                begin
                    t = {r, div_reg[PADW-1-i]};
                    if (t >= DEPTH_R)
                    begin
                        t = t - DEPTH_R;
                    end
                    r = t[IDX_W-1:0];
                end
                if (start)
                begin
                    busy_next = 1'b1;
                    div_next  = PADW'(key[KEY_BITS-1:WORD_SHIFT]);
                    rem_next  = '0;
                    step_next = '0;
                end
                else if (busy_reg)
                begin
                    rem_next  = r;
                    div_next  = div_reg << DIGIT;
                    step_next = step_reg + 1'b1;
                    if (step_reg == SW'(STEPS - 1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    div_reg  <= '0;
                    rem_reg  <= '0;
                    step_reg <= '0;
                end
                else
                begin
                    busy_reg <= busy_next;
                    done_reg <= done_next;
                    div_reg  <= div_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_next;
                end
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate

endmodule

### rtl/aht_store.sv
// ----------------------------------------------------------------------------
// aht_store
// Slot memory: one key and count per slot, one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module aht_store import aht_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_BITS    = DEF_ADDRESS_BITS
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]  wr_idx,
    input  logic [KEY_BITS-1:0]             wr_key,
    input  logic [COUNT_W-1:0]              wr_count,
    input  logic [$clog2(TABLE_DEPTH)-1:0]  rd_idx,
    output logic [KEY_BITS-1:0]             rd_key,
    output logic [COUNT_W-1:0]              rd_count
);

    localparam int WORD_W = KEY_BITS + COUNT_W;

    logic [WORD_W-1:0] slot_mem [TABLE_DEPTH];
    logic [WORD_W-1:0] rd_word_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_idx] <= {wr_key, wr_count};
        end
        rd_word_reg <= slot_mem[rd_idx];
    end

    assign rd_key   = rd_word_reg[WORD_W-1:COUNT_W];
    assign rd_count = rd_word_reg[COUNT_W-1:0];

endmodule

### rtl/address_refcount_hash_table.sv
// ----------------------------------------------------------------------------
// address_refcount_hash_table
// Linear-probing table from object addresses to reference counts.
// ----------------------------------------------------------------------------
// Channels: req carries kind, address and new_count; rsp returns status,
// count_out and slot. Each transfer on req yields exactly one rsp transfer.
// After reset the slot memory is cleared in S_CLEAR, one slot a cycle;
// req.ready stays low during that pass. An accepted item waits in S_HOME
// for the home slot, then probes in S_PROBE (one slot read per cycle from
// the slot memory, 1 to TABLE_DEPTH slots) and posts its result in S_REPLY.
// Zero-address items and inserts into a full table skip S_HOME and S_PROBE.
// req.ready rises in the same cycle as rsp.valid. The result sits in an
// output register; the next item is accepted and processed while it waits,
// and only its own S_REPLY step (result posting and slot write) holds off
// until rsp.ready frees the register.
// ----------------------------------------------------------------------------
module address_refcount_hash_table import aht_pkg::*; #(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    aht_req_if.sink     req,
    aht_rsp_if.source   rsp
);

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int CNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_BITS = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_MARK = CNT_W'(TABLE_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME,
        S_PROBE,
        S_REPLY
    } state_t;

    state_t               state_reg,       state_next;
    logic [IDX_W-1:0]     clr_idx_reg,     clr_idx_next;
    kind_t                kind_reg,        kind_next;
    logic [KEY_BITS-1:0]  key_reg,         key_next;
    logic [COUNT_W-1:0]   cnt_reg,         cnt_next;
    logic [IDX_W-1:0]     idx_reg,         idx_next;
    logic [IDX_W-1:0]     probe_n_reg,     probe_n_next;
    status_t              status_reg,      status_next;
    logic [IDX_W-1:0]     where_reg,       where_next;
    logic [COUNT_W-1:0]   found_count_reg, found_count_next;
    logic [CNT_W-1:0]     entry_reg,       entry_next;
    logic                 rsp_valid_reg,   rsp_valid_next;
    status_t              rsp_status_reg,  rsp_status_next;
    logic [COUNT_W-1:0]   rsp_count_reg,   rsp_count_next;
    logic [SLOT_W-1:0]    rsp_slot_reg,    rsp_slot_next;

    logic                 accept;
    logic [KEY_BITS-1:0]  key_in;
    logic                 home_start;
    logic                 home_done;
    logic [IDX_W-1:0]     home_idx;
    logic [IDX_W-1:0]     idx_wrap;
    logic [IDX_W-1:0]     rd_idx;
    logic [KEY_BITS-1:0]  rd_key;
    logic [COUNT_W-1:0]   rd_count;
    logic                 hit;
    logic                 out_free;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic [KEY_BITS-1:0]  wr_key;
    logic [COUNT_W-1:0]   wr_count;
    logic                 wr_blank;
    logic [IDX_W+SLOT_W-1:0] slot_ext;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign key_in    = req.address[KEY_BITS-1:0];
    assign home_start = accept && (key_in != '0)
                        && !((req.kind == KIND_INSERT) && (entry_reg >= FULL_MARK));

    aht_home #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (home_start),
        .key   (key_in),
        .done  (home_done),
        .home  (home_idx)
    );

    assign idx_wrap = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign rd_idx   = (state_reg == S_HOME) ? home_idx : idx_wrap;

    aht_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx),
        .wr_key   (wr_key),
        .wr_count (wr_count),
        .rd_idx   (rd_idx),
        .rd_key   (rd_key),
        .rd_count (rd_count)
    );

    assign hit      = (kind_reg == KIND_INSERT) ? (rd_key == '0) : (rd_key == key_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign slot_ext = {{SLOT_W{1'b0}}, where_reg};

    assign wr_blank = (state_reg == S_CLEAR) || (kind_reg == KIND_DELETE);
    assign wr_en    = (state_reg == S_CLEAR)
                      || ((state_reg == S_REPLY) && out_free && (status_reg == STATUS_OK)
                          && (kind_reg != KIND_LOOKUP));
    assign wr_idx   = (state_reg == S_CLEAR) ? clr_idx_reg : where_reg;
    assign wr_key   = wr_blank ? '0 : key_reg;
    assign wr_count = wr_blank ? '0 : cnt_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        kind_next        = kind_reg;
        key_next         = key_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        probe_n_next     = probe_n_reg;
        status_next      = status_reg;
        where_next       = where_reg;
        found_count_next = found_count_reg;
        entry_next       = entry_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_count_next   = rsp_count_reg;
        rsp_slot_next    = rsp_slot_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next        = req.kind;
                    key_next         = key_in;
                    cnt_next         = req.new_count;
                    where_next       = '0;
                    found_count_next = '0;
                    if (key_in == '0)
                    begin
                        status_next = STATUS_ZERO_ADDR;
                        state_next  = S_REPLY;
                    end
                    else if ((req.kind == KIND_INSERT) && (entry_reg >= FULL_MARK))
                    begin
                        status_next = STATUS_FULL;
                        state_next  = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_HOME;
                    end
                end
            end
            S_HOME:
            begin
                if (home_done)
                begin
                    idx_next     = home_idx;
                    probe_n_next = '0;
                    state_next   = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (hit)
                begin
                    status_next = STATUS_OK;
                    where_next  = idx_reg;
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        found_count_next = rd_count;
                    end
                    state_next = S_REPLY;
                end
                else if (probe_n_reg == LAST_IDX)
                begin
                    status_next = (kind_reg == KIND_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
                    where_next  = '0;
                    state_next  = S_REPLY;
                end
                else
                begin
                    idx_next     = idx_wrap;
                    probe_n_next = probe_n_reg + 1'b1;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_count_next  = found_count_reg;
                    rsp_slot_next   = slot_ext[SLOT_W-1:0];
                    if (status_reg == STATUS_OK)
                    begin
                        if (kind_reg == KIND_INSERT)
                        begin
                            entry_next = entry_reg + 1'b1;
                        end
                        else if ((kind_reg == KIND_DELETE) && (entry_reg != '0))
                        begin
                            entry_next = entry_reg - 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_idx_reg     <= '0;
            kind_reg        <= KIND_INSERT;
            key_reg         <= '0;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            probe_n_reg     <= '0;
            status_reg      <= STATUS_OK;
            where_reg       <= '0;
            found_count_reg <= '0;
            entry_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_status_reg  <= STATUS_OK;
            rsp_count_reg   <= '0;
            rsp_slot_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_idx_reg     <= clr_idx_next;
            kind_reg        <= kind_next;
            key_reg         <= key_next;
            cnt_reg         <= cnt_next;
            idx_reg         <= idx_next;
            probe_n_reg     <= probe_n_next;
            status_reg      <= status_next;
            where_reg       <= where_next;
            found_count_reg <= found_count_next;
            entry_reg       <= entry_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_status_reg  <= rsp_status_next;
            rsp_count_reg   <= rsp_count_next;
            rsp_slot_reg    <= rsp_slot_next;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.count_out = rsp_count_reg;
    assign rsp.slot      = rsp_slot_reg;

    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_reg <= FULL_MARK)
        else $error("entry count above table limit");

    a_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (key_in == '0) |=> (state_reg == S_REPLY)
                                     && (status_reg == STATUS_ZERO_ADDR))
        else $error("zero address not rejected");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !rsp_valid_reg)
        else $error("result posted during clearing pass");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_status_reg != STATUS_OK)
            |-> (rsp_slot_reg == '0) && (rsp_count_reg == '0))
        else $error("failed result carries nonzero slot or count");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) && !hit && (probe_n_reg == LAST_IDX)
            |=> (state_reg == S_REPLY) && (where_reg == '0))
        else $error("probe ran past table depth");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the address reference-count hash table against a predictor that
// keeps its own copy of the slots and the entry count. Directed requests
// cover zero addresses, misses, wraparound, duplicates and every operation.
// Random phases then churn the table, fill it to the refusal point and
// drain it, with random idling on both channels and one long response
// hold-off that backs the table up.
// ----------------------------------------------------------------------------
module testbench;

    import aht_pkg::*;

    localparam int TABLE_DEPTH      = DEF_TABLE_DEPTH;
    localparam int RANDOM_ITEMS     = 1350;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 4000;
    localparam int TAIL_CYCLES      = 80;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SLOT_W-1:0]  slot_t;

    typedef struct packed {
        status_t status;
        count_t  count_out;
        slot_t   slot;
    } table_response_t;

    class refcount_scoreboard;
        addr_t           key_at [TABLE_DEPTH];
        count_t          count_at [TABLE_DEPTH];
        int unsigned     occupied;
        table_response_t awaited_responses [$];
        int unsigned     mismatches;

        function new();
            foreach (key_at[i])
            begin
                key_at[i]   = '0;
                count_at[i] = '0;
            end
            occupied   = 0;
            mismatches = 0;
        endfunction

        function int unsigned home_slot(addr_t addr);
            return int'((addr >> WORD_SHIFT) % TABLE_DEPTH);
        endfunction

        function int find_key(addr_t addr);
            int unsigned idx;
            idx = home_slot(addr);
            for (int n = 0; n < TABLE_DEPTH; n++)
            begin
                if (key_at[idx] == addr)
                    return int'(idx);
                idx = (idx + 1) % TABLE_DEPTH;
            end
            return -1;
        endfunction

        function addr_t live_address();
            int unsigned idx;
            idx = $urandom_range(0, TABLE_DEPTH - 1);
            for (int n = 0; n < TABLE_DEPTH; n++)
            begin
                if (key_at[idx] != 0)
                    return key_at[idx];
                idx = (idx + 1) % TABLE_DEPTH;
            end
            return '0;
        endfunction

        function void apply_request(kind_t kind, addr_t addr, count_t new_count);
            table_response_t rsp;
            int unsigned     idx;
            int              hit;
            rsp = '{STATUS_OK, '0, '0};
            if (addr == 0)
                rsp.status = STATUS_ZERO_ADDR;
            else if (kind == KIND_INSERT)
            begin
                rsp.status = STATUS_FULL;
                if (occupied + 1 < TABLE_DEPTH)
                begin
                    idx = home_slot(addr);
                    for (int n = 0; n < TABLE_DEPTH; n++)
                    begin
                        if (key_at[idx] == 0)
                        begin
                            key_at[idx]   = addr;
                            count_at[idx] = new_count;
                            occupied++;
                            rsp.status = STATUS_OK;
                            rsp.slot   = SLOT_W'(idx);
                            break;
                        end
                        idx = (idx + 1) % TABLE_DEPTH;
                    end
                end
            end
            else
            begin
                hit = find_key(addr);
                if (hit < 0)
                    rsp.status = STATUS_NOT_FOUND;
                else
                begin
                    rsp.slot = SLOT_W'(hit);
                    case (kind)
                        KIND_DELETE:
                        begin
                            key_at[hit]   = '0;
                            count_at[hit] = '0;
                            if (occupied > 0)
                                occupied--;
                        end
                        KIND_LOOKUP: rsp.count_out = count_at[hit];
                        default:     count_at[hit] = new_count;
                    endcase
                end
            end
            awaited_responses.push_back(rsp);
        endfunction

        function void check_response(status_t status, count_t count_out, slot_t slot);
            table_response_t want;
            if (awaited_responses.size() == 0)
            begin
                $error("unexpected response: status %0d count_out %0h slot %0d",
                       status, count_out, slot);
                mismatches++;
                return;
            end
            want = awaited_responses.pop_front();
            if (status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, status);
                mismatches++;
            end
            if (count_out !== want.count_out)
            begin
                $error("count_out: expected %0h, actual %0h", want.count_out, count_out);
                mismatches++;
            end
            if (slot !== want.slot)
            begin
                $error("slot: expected %0d, actual %0d", want.slot, slot);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_responses.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    aht_req_if req_ch ();
    aht_rsp_if rsp_ch ();

    address_refcount_hash_table u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    refcount_scoreboard sb = new();

    bit          gaps_on      = 1'b1;
    bit          hold_off_req = 1'b0;
    int unsigned accepted     = 0;
    int unsigned idle_cycles  = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic int unsigned sender_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned receiver_stall();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic addr_t random_address();
        addr_t       a;
        int unsigned r;
        a = ADDR_W'({$urandom, $urandom});
        r = $urandom_range(0, 9);
        if (r < 5)
            a[WORD_SHIFT +: SLOT_W] = $urandom_range(0, 1) ?
                SLOT_W'($urandom_range(0, 2)) : SLOT_W'($urandom_range(61, 63));
        if (r == 9)
            a[ADDR_W-1 -: 16] = '1;
        if (a == 0)
            a = addr_t'(4);
        return a;
    endfunction

    task automatic issue_request(kind_t kind, addr_t addr, count_t new_count);
        int unsigned gap;
        gap = gaps_on ? sender_gap() : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.kind      <= kind;
        req_ch.address   <= addr;
        req_ch.new_count <= new_count;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        sb.apply_request(kind, addr, new_count);
        accepted++;
    endtask

    task automatic on_live(kind_t kind);
        addr_t a;
        a = sb.live_address();
        if (a == 0)
            a = random_address();
        issue_request(kind, a, $urandom);
    endtask

    task automatic run_directed();
        issue_request(KIND_INSERT, '0, 32'h1234_5678);
        issue_request(KIND_DELETE, '0, '0);
        issue_request(KIND_LOOKUP, '0, '0);
        issue_request(KIND_SET, '0, '1);
        issue_request(KIND_LOOKUP, 48'h1000, '0);
        issue_request(KIND_DELETE, 48'h1000, '0);
        issue_request(KIND_SET, 48'h1000, 32'h5);
        issue_request(KIND_INSERT, '1, '1);
        issue_request(KIND_INSERT, 48'hFC, '0);
        issue_request(KIND_INSERT, 48'h4, 32'h1);
        issue_request(KIND_LOOKUP, 48'hFC, '0);
        issue_request(KIND_LOOKUP, '1, '0);
        issue_request(KIND_INSERT, '1, 32'h5);
        issue_request(KIND_LOOKUP, '1, '0);
        issue_request(KIND_DELETE, '1, '0);
        issue_request(KIND_LOOKUP, '1, '0);
        issue_request(KIND_SET, '1, 32'h8000_0001);
        issue_request(KIND_LOOKUP, '1, '0);
        issue_request(KIND_INSERT, 48'h3, 32'hFFFF_0000);
        issue_request(KIND_LOOKUP, 48'h3, '0);
        issue_request(KIND_DELETE, 48'hFC, '0);
        issue_request(KIND_DELETE, 48'h4, '0);
        issue_request(KIND_DELETE, '1, '0);
        issue_request(KIND_DELETE, 48'h3, '0);
    endtask

    task automatic run_churn(int unsigned n);
        int unsigned r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                issue_request(kind_t'($urandom_range(0, 3)),
                              $urandom_range(0, 1) ? addr_t'(0) : random_address(), $urandom);
            else if (r < 14)
                on_live(KIND_INSERT);
            else if (r < 38)
                issue_request(KIND_INSERT, random_address(), $urandom);
            else if (r < 62)
                on_live(KIND_LOOKUP);
            else if (r < 77)
                on_live(KIND_SET);
            else
                on_live(KIND_DELETE);
        end
    endtask

    task automatic run_fill_and_drain();
        while (sb.occupied < TABLE_DEPTH - 1)
            issue_request(KIND_INSERT, random_address(), $urandom);
        repeat (3) issue_request(KIND_INSERT, random_address(), $urandom);
        repeat (4) on_live(KIND_LOOKUP);
        repeat (3) issue_request(KIND_LOOKUP, random_address(), '0);
        repeat (3) on_live(KIND_SET);
        while (sb.occupied > 0)
        begin
            if ($urandom_range(0, 4) == 0)
                on_live(KIND_LOOKUP);
            else
                on_live(KIND_DELETE);
        end
    endtask

    initial
    begin : stimulus
        req_ch.valid     <= 1'b0;
        req_ch.kind      <= KIND_INSERT;
        req_ch.address   <= '0;
        req_ch.new_count <= '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        gaps_on      = 1'b0;
        hold_off_req = 1'b1;
        run_churn(40);
        gaps_on = 1'b1;
        run_fill_and_drain();

        while (accepted < RANDOM_ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                run_fill_and_drain();
            else
                run_churn(50);
        end
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : receiver
        int unsigned stall;
        rsp_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            stall = gaps_on ? receiver_stall() : 0;
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            sb.check_response(rsp_ch.status, rsp_ch.count_out, rsp_ch.slot);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

### filelist.f
rtl/aht_pkg.sv
rtl/aht_req_if.sv
rtl/aht_rsp_if.sv
rtl/aht_home.sv
rtl/aht_store.sv
rtl/address_refcount_hash_table.sv
sim/testbench.sv
